@@ rtl/lgs_pkg.sv @@
// Shared types, codes and defaults of the Gaussian elimination solver.
`default_nettype none
package lgs_pkg;

	// Default sizing
	localparam int MAX_SIZE_DEF    = 8;
	localparam int VALUE_WIDTH_DEF = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0]  CFG_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_PIVOT  = 1'd1;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 4'd8;

	// Result status codes
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ZERO_DIAG  = 2'd1;
	localparam logic [1:0] ST_ZERO_PIVOT = 2'd2;
	localparam logic [1:0] ST_SAT        = 2'd3;

	// Matrix memory write data select
	typedef logic [2:0] wsel_t;
	localparam wsel_t WR_IN    = 3'd0;
	localparam wsel_t WR_CLAMP = 3'd1;
	localparam wsel_t WR_TMP   = 3'd2;
	localparam wsel_t WR_RD    = 3'd3;
	localparam wsel_t WR_DIFF  = 3'd4;

	// Divider operand select
	localparam logic DIV_F = 1'b0;  // row element over pivot
	localparam logic DIV_X = 1'b1;  // numerator register over diagonal

	// Multiplier operand select
	localparam logic MUL_F = 1'b0;  // times elimination factor
	localparam logic MUL_S = 1'b1;  // times stored unknown

	// Controller to datapath commands
	typedef struct packed {
		logic       sat_clr;
		logic       ram_re;
		logic       ram_we;
		wsel_t      wsel;
		logic       ld_t;
		logic       ld_best;
		logic       ld_piv;
		logic       div_start;
		logic       div_sel;
		logic       ld_f;
		logic       mul_start;
		logic       mul_sel;
		logic       acc_clr;
		logic       acc_add;
		logic       ld_num;
		logic       sol_we;
		logic       out_en;
		logic       out_abort;
		logic [1:0] out_code;
		logic       out_last;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic rd_zero;
		logic mag_gt;
		logic div_done;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/linear_system_gauss_solver.sv @@
// Top level of the fixed-point Gaussian elimination solver.
//
// Usage. Coefficients of the augmented matrix (n rows by n+1 columns, signed
// Q16.16, row-major) enter one per cycle: a transaction is taken at each
// rising edge with start high and busy low. The item with last_element set
// ends the matrix and starts the solve; busy stays high until the solve ends.
// Configuration (system_size at index 0, pivot_mode at index 1) is written
// through cfg_valid/cfg_index/cfg_data; the user must write it only while the
// block is idle, which the block itself does not enforce; cfg_ready is always high.
// The solve first clamps every stored coefficient to the working range, then
// eliminates column by column with one divide per eliminated row, and then
// back-substitutes with one divide per unknown. The matrix memory has one
// write port and one read port, and the divider is bit-serial.
// Results leave from unknown n-1 down to 0, one cycle each with result_valid
// high; the receiver cannot stall them. An abort gives a single result.
// Reset (arst_n low) returns to idle, size 8, plain mode, load position zero;
// the matrix memory is not cleared.
`default_nettype none
module linear_system_gauss_solver
	import lgs_pkg::*;
#(
	parameter int MAX_SIZE    = MAX_SIZE_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic signed [31:0]    coefficient,
	input  logic                  last_element,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  result_valid,
	output logic signed [31:0]    solution,
	output logic [2:0]            unknown_index,
	output logic [1:0]            status,
	output logic                  last_result
);

	localparam int AW = $clog2(MAX_SIZE * (MAX_SIZE + 1));
	localparam int XW = $clog2(MAX_SIZE);

	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic [XW-1:0] sol_ridx;
	logic [XW-1:0] sol_widx;

	// Sequencer
	lgs_ctrl #(
		.MAX_SIZE(MAX_SIZE)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_element(last_element),
		.busy        (busy),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.raddr       (raddr),
		.waddr       (waddr),
		.sol_ridx    (sol_ridx),
		.sol_widx    (sol_widx)
	);

	// Arithmetic and storage
	lgs_dp #(
		.MAX_SIZE   (MAX_SIZE),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.raddr        (raddr),
		.waddr        (waddr),
		.sol_ridx     (sol_ridx),
		.sol_widx     (sol_widx),
		.coefficient  (coefficient),
		.result_valid (result_valid),
		.solution     (solution),
		.unknown_index(unknown_index),
		.status       (status),
		.last_result  (last_result)
	);

endmodule
`default_nettype wire

@@ rtl/lgs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 72
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/lgs_div.sv @@
// Iterative signed fixed-point divider, one quotient bit per cycle, rounded and saturated.
`default_nettype none
module lgs_div
	import lgs_pkg::*;
#(
	parameter int W = VALUE_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo,
	output logic         sat
);

	localparam int NW  = W + 16;
	localparam int CNW = $clog2(NW + 1);
	localparam int QW  = NW + 1;
	localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

	logic           run_q;
	logic [CNW-1:0] cnt_q;
	logic           done_q;
	logic [NW-1:0]  nb_q;
	logic [W-1:0]   rem_q;
	logic [NW-1:0]  q_q;
	logic [W-1:0]   ub_q;
	logic           neg_q;
	logic [W-1:0]   quo_q;
	logic           sat_q;

	logic [W:0]     remsh;
	logic           ge;
	logic [W:0]     remnx;
	logic           rup;
	logic [QW-1:0]  qf;
	logic [QW-1:0]  lim;
	logic           fsat;
	logic [W-1:0]   fres;

	function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
		mag_f = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// One restoring step and the final rounding
	always_comb begin
		remsh = {rem_q, nb_q[NW-1]};
		ge    = remsh >= {1'b0, ub_q};
		remnx = ge ? (remsh - {1'b0, ub_q}) : remsh;
		rup   = {rem_q, 1'b0} >= {1'b0, ub_q};
		qf    = {1'b0, q_q} + QW'(rup);
		lim   = QW'(VMAX) + QW'(neg_q);
		fsat  = (ub_q != '0) && (qf > lim);
		if (ub_q == '0) begin
			fres = '0;
		end else if (fsat) begin
			fres = neg_q ? VMIN : VMAX;
		end else begin
			fres = neg_q ? (~qf[W-1:0] + 1'b1) : qf[W-1:0];
		end
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNW'(NW);
			end else if (run_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			nb_q  <= {mag_f(num), 16'b0};
			rem_q <= '0;
			q_q   <= '0;
			ub_q  <= mag_f(den);
			neg_q <= num[W-1] ^ den[W-1];
		end else if (run_q) begin
			if (cnt_q != '0) begin
				nb_q  <= {nb_q[NW-2:0], 1'b0};
				rem_q <= remnx[W-1:0];
				q_q   <= {q_q[NW-2:0], ge};
			end else begin
				quo_q <= fres;
				sat_q <= fsat;
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign sat  = sat_q;

endmodule
`default_nettype wire

@@ rtl/lgs_dp.sv @@
// Datapath: matrix memory, unknown store, multiplier, divider, saturating arithmetic.
`default_nettype none
module lgs_dp
	import lgs_pkg::*;
#(
	parameter int MAX_SIZE    = MAX_SIZE_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  cmd_t                                     cmd,
	output sts_t                                     sts,
	input  logic [$clog2(MAX_SIZE*(MAX_SIZE+1))-1:0] raddr,
	input  logic [$clog2(MAX_SIZE*(MAX_SIZE+1))-1:0] waddr,
	input  logic [$clog2(MAX_SIZE)-1:0]              sol_ridx,
	input  logic [$clog2(MAX_SIZE)-1:0]              sol_widx,
	input  logic signed [31:0]                       coefficient,
	output logic                                     result_valid,
	output logic signed [31:0]                       solution,
	output logic [2:0]                               unknown_index,
	output logic [1:0]                               status,
	output logic                                     last_result
);

	localparam int W     = VALUE_WIDTH;
	localparam int SW    = (W > 32) ? W : 32;
	localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1);
	localparam int PW    = 2 * W + 1;
	localparam logic [W-1:0]  VMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  VMIN   = {1'b1, {(W-1){1'b0}}};
	localparam logic [SW-1:0] CLMAX  = SW'(VMAX);
	localparam logic [SW-1:0] CLMIN  = ~CLMAX;
	localparam logic [SW-1:0] O32MAX = SW'(32'h7fff_ffff);
	localparam logic [SW-1:0] O32MIN = ~O32MAX;

	logic [SW-1:0]  rdata;
	logic [W-1:0]   rd_w;
	logic [SW-1:0]  wdata;
	logic [W-1:0]   sol_q [MAX_SIZE];
	logic [SW-1:0]  t_q;
	logic [W-1:0]   best_q;
	logic [W-1:0]   piv_q;
	logic [W-1:0]   f_q;
	logic [W-1:0]   acc_q;
	logic [W-1:0]   num_q;
	logic [2*W-1:0] prod_q;
	logic           pneg_q;
	logic           sat_q;

	logic [W-1:0]   clamp_v;
	logic           clamp_sat;
	logic [W-1:0]   mb;
	logic [PW-1:0]  mrnd;
	logic [PW-1:0]  mlim;
	logic           mres_sat;
	logic [W-1:0]   mres;
	logic [W:0]     diff;
	logic [W:0]     sum;
	logic [W:0]     numd;
	logic [W-1:0]   div_num;
	logic [W-1:0]   div_den;
	logic           div_done;
	logic [W-1:0]   quo;
	logic           div_sat;
	logic [SW-1:0]  xs;
	logic [31:0]    x32;
	logic           o32_sat;
	logic           sat_set;

	logic           rv_q;
	logic [31:0]    sol_out_q;
	logic [2:0]     idx_q;
	logic [1:0]     st_q;
	logic           last_q;

	function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
		mag_f = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// Saturating add or subtract; top bit flags saturation
	function automatic logic [W:0] addsat(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic do_sub);
		logic [W-1:0] bb;
		logic [W-1:0] r;
		logic         ovf;
		bb  = do_sub ? ~b : b;
		r   = a + bb + W'(do_sub);
		ovf = (a[W-1] == bb[W-1]) && (r[W-1] != a[W-1]);
		addsat = {ovf, ovf ? (a[W-1] ? VMIN : VMAX) : r};
	endfunction

	// Matrix memory
	lgs_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_mat (
		.clk  (clk),
		.we   (cmd.ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_w = rdata[W-1:0];

	// Input range clamp to the working width
	always_comb begin
		clamp_sat = 1'b1;
		if ($signed(rdata) > $signed(CLMAX)) begin
			clamp_v = VMAX;
		end else if ($signed(rdata) < $signed(CLMIN)) begin
			clamp_v = VMIN;
		end else begin
			clamp_v   = rd_w;
			clamp_sat = 1'b0;
		end
	end

	// Product rounding, half away from zero, then saturation
	always_comb begin
		mb       = (cmd.mul_sel == MUL_F) ? f_q : sol_q[sol_ridx];
		mrnd     = (PW'(prod_q) + PW'(17'h8000)) >> 16;
		mlim     = PW'(VMAX) + PW'(pneg_q);
		mres_sat = mrnd > mlim;
		if (mres_sat) begin
			mres = pneg_q ? VMIN : VMAX;
		end else begin
			mres = pneg_q ? (~mrnd[W-1:0] + 1'b1) : mrnd[W-1:0];
		end
	end

	// Saturating sums
	assign diff = addsat(rd_w, mres, 1'b1);
	assign sum  = addsat(acc_q, mres, 1'b0);
	assign numd = addsat(rd_w, acc_q, 1'b1);

	// Divider
	assign div_num = (cmd.div_sel == DIV_F) ? rd_w : num_q;
	assign div_den = (cmd.div_sel == DIV_F) ? piv_q : rd_w;

	lgs_div #(
		.W(W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (quo),
		.sat   (div_sat)
	);

	// Unknown narrowed to the 32-bit result
	always_comb begin
		xs      = SW'($signed(quo));
		o32_sat = 1'b1;
		if ($signed(xs) > $signed(O32MAX)) begin
			x32 = O32MAX[31:0];
		end else if ($signed(xs) < $signed(O32MIN)) begin
			x32 = O32MIN[31:0];
		end else begin
			x32     = xs[31:0];
			o32_sat = 1'b0;
		end
	end

	// Memory write data
	always_comb begin
		case (cmd.wsel)
			WR_IN:    wdata = SW'(coefficient);
			WR_CLAMP: wdata = SW'($signed(clamp_v));
			WR_TMP:   wdata = t_q;
			WR_RD:    wdata = rdata;
			WR_DIFF:  wdata = SW'($signed(diff[W-1:0]));
			default:  wdata = rdata;
		endcase
	end

	// Sticky saturation sources
	always_comb begin
		sat_set = 1'b0;
		if (cmd.ram_we && cmd.wsel == WR_CLAMP) begin
			sat_set = clamp_sat;
		end
		if (cmd.ram_we && cmd.wsel == WR_DIFF) begin
			sat_set = diff[W] | mres_sat;
		end
		if (cmd.acc_add) begin
			sat_set = sum[W] | mres_sat;
		end
		if (cmd.ld_num) begin
			sat_set = numd[W];
		end
		// elimination factor may saturate too
		if (cmd.ld_f) begin
			sat_set = div_sat;
		end
		if (cmd.out_en && !cmd.out_abort) begin
			sat_set = div_sat | o32_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.sat_clr) begin
			sat_q <= 1'b0;
		end else if (sat_set) begin
			sat_q <= 1'b1;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.ld_t) begin
			t_q <= rdata;
		end
		if (cmd.ld_best) begin
			best_q <= mag_f(rd_w);
		end
		if (cmd.ld_piv) begin
			piv_q <= rd_w;
		end
		if (cmd.ld_f) begin
			f_q <= quo;
		end
		if (cmd.mul_start) begin
			prod_q <= (2*W)'(mag_f(rd_w)) * (2*W)'(mag_f(mb));
			pneg_q <= rd_w[W-1] ^ mb[W-1];
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= sum[W-1:0];
		end
		if (cmd.ld_num) begin
			num_q <= numd[W-1:0];
		end
		if (cmd.sol_we) begin
			sol_q[sol_widx] <= quo;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q <= 1'b0;
		end else begin
			rv_q <= cmd.out_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_en) begin
			if (cmd.out_abort) begin
				sol_out_q <= '0;
				idx_q     <= '0;
				st_q      <= cmd.out_code;
				last_q    <= 1'b1;
			end else begin
				sol_out_q <= x32;
				idx_q     <= 3'(sol_widx);
				st_q      <= (sat_q | div_sat | o32_sat) ? ST_SAT : ST_OK;
				last_q    <= cmd.out_last;
			end
		end
	end

	assign sts.rd_zero  = (rd_w == '0);
	assign sts.mag_gt   = (mag_f(rd_w) > best_q);
	assign sts.div_done = div_done;

	assign result_valid  = rv_q;
	assign solution      = sol_out_q;
	assign unknown_index = idx_q;
	assign status        = st_q;
	assign last_result   = last_q;

endmodule
`default_nettype wire

@@ rtl/lgs_ctrl.sv @@
// Controller: configuration registers, load counter and the elimination sequencer.
`default_nettype none
module lgs_ctrl
	import lgs_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	input  logic                                     last_element,
	output logic                                     busy,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]                     cfg_index,
	input  logic [CFG_DATA_W-1:0]                    cfg_data,
	output cmd_t                                     cmd,
	input  sts_t                                     sts,
	output logic [$clog2(MAX_SIZE*(MAX_SIZE+1))-1:0] raddr,
	output logic [$clog2(MAX_SIZE*(MAX_SIZE+1))-1:0] waddr,
	output logic [$clog2(MAX_SIZE)-1:0]              sol_ridx,
	output logic [$clog2(MAX_SIZE)-1:0]              sol_widx
);

	localparam int DEPTH = MAX_SIZE * (MAX_SIZE + 1);
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int IW    = $clog2(MAX_SIZE + 1);
	localparam int SZW   = $clog2(MAX_SIZE + 2);
	localparam int XW    = $clog2(MAX_SIZE);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_CL_RD   = 5'd1;
	localparam logic [4:0] S_CL_WR   = 5'd2;
	localparam logic [4:0] S_ZD_RD   = 5'd3;
	localparam logic [4:0] S_ZD_CK   = 5'd4;
	localparam logic [4:0] S_EL_TOP  = 5'd5;
	localparam logic [4:0] S_PV_RD0  = 5'd6;
	localparam logic [4:0] S_PV_BEST = 5'd7;
	localparam logic [4:0] S_PV_RD   = 5'd8;
	localparam logic [4:0] S_PV_CMP  = 5'd9;
	localparam logic [4:0] S_SW_A    = 5'd10;
	localparam logic [4:0] S_SW_B    = 5'd11;
	localparam logic [4:0] S_SW_C    = 5'd12;
	localparam logic [4:0] S_SW_D    = 5'd13;
	localparam logic [4:0] S_PP_RD   = 5'd14;
	localparam logic [4:0] S_PP_CK   = 5'd15;
	localparam logic [4:0] S_RW_RD   = 5'd16;
	localparam logic [4:0] S_RW_DIV  = 5'd17;
	localparam logic [4:0] S_RW_WAIT = 5'd18;
	localparam logic [4:0] S_EL_A    = 5'd19;
	localparam logic [4:0] S_EL_B    = 5'd20;
	localparam logic [4:0] S_EL_C    = 5'd21;
	localparam logic [4:0] S_FIN_RD  = 5'd22;
	localparam logic [4:0] S_FIN_CK  = 5'd23;
	localparam logic [4:0] S_BS_TOP  = 5'd24;
	localparam logic [4:0] S_BS_RD   = 5'd25;
	localparam logic [4:0] S_BS_MUL  = 5'd26;
	localparam logic [4:0] S_BS_ADD  = 5'd27;
	localparam logic [4:0] S_BS_NRD  = 5'd28;
	localparam logic [4:0] S_BS_NUM  = 5'd29;
	localparam logic [4:0] S_BS_DIV  = 5'd30;
	localparam logic [4:0] S_BS_WAIT = 5'd31;

	logic [4:0]            state_q;
	logic [CFG_DATA_W-1:0] size_q;
	logic                  pivot_q;
	logic [LW-1:0]         lp_q;
	logic [IW-1:0]         n_q;
	logic [SZW-1:0]        s_q;
	logic [LW-1:0]         cells_q;
	logic [LW-1:0]         i_q;
	logic [IW-1:0]         c_q;
	logic [IW-1:0]         k_q;
	logic [IW-1:0]         l_q;
	logic [IW-1:0]         r_q;
	logic [IW-1:0]         p_q;

	logic [IW-1:0]         n_live;
	logic [LW-1:0]         cells_live;
	logic [IW-1:0]         n_m1;
	logic [IW-1:0]         p_nx;

	function automatic logic [AW-1:0] rc(input logic [IW-1:0] row, input logic [IW-1:0] col,
			input logic [SZW-1:0] stride);
		rc = AW'(32'(row) * 32'(stride) + 32'(col));
	endfunction

	// Size in force: zero acts as one, oversize acts as the maximum
	always_comb begin
		if (size_q == '0) begin
			n_live = IW'(1);
		end else if ({1'b0, size_q} > 5'(MAX_SIZE)) begin
			n_live = IW'(MAX_SIZE);
		end else begin
			n_live = IW'(size_q);
		end
		cells_live = LW'(32'(n_live) * (32'(n_live) + 32'd1));
		n_m1       = n_q - IW'(1);
		p_nx       = sts.mag_gt ? r_q : p_q;
	end

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign sol_ridx  = l_q[XW-1:0];
	assign sol_widx  = k_q[XW-1:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RESET;
			pivot_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SIZE:  size_q  <= cfg_data;
				CFG_PIVOT: pivot_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Commands and memory addresses per state
	always_comb begin
		cmd   = '0;
		raddr = '0;
		waddr = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ram_we  = start && (lp_q < cells_live);
				cmd.wsel    = WR_IN;
				waddr       = lp_q[AW-1:0];
				cmd.sat_clr = start && last_element;
			end
			S_CL_RD: begin
				cmd.ram_re = 1'b1;
				raddr      = i_q[AW-1:0];
			end
			S_CL_WR: begin
				cmd.ram_we = 1'b1;
				cmd.wsel   = WR_CLAMP;
				waddr      = i_q[AW-1:0];
			end
			S_ZD_RD: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(k_q, k_q, s_q);
			end
			S_ZD_CK: begin
				if (sts.rd_zero) begin
					cmd.out_en    = 1'b1;
					cmd.out_abort = 1'b1;
					cmd.out_code  = ST_ZERO_DIAG;
					cmd.out_last  = 1'b1;
				end
			end
			S_EL_TOP: ;
			S_PV_RD0: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(c_q, c_q, s_q);
			end
			S_PV_BEST: cmd.ld_best = 1'b1;
			S_PV_RD: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(r_q, c_q, s_q);
			end
			S_PV_CMP: cmd.ld_best = sts.mag_gt;
			S_SW_A: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(c_q, l_q, s_q);
			end
			S_SW_B: begin
				cmd.ld_t   = 1'b1;
				cmd.ram_re = 1'b1;
				raddr      = rc(p_q, l_q, s_q);
			end
			S_SW_C: begin
				cmd.ram_we = 1'b1;
				cmd.wsel   = WR_RD;
				waddr      = rc(c_q, l_q, s_q);
			end
			S_SW_D: begin
				cmd.ram_we = 1'b1;
				cmd.wsel   = WR_TMP;
				waddr      = rc(p_q, l_q, s_q);
			end
			S_PP_RD: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(c_q, c_q, s_q);
			end
			S_PP_CK: begin
				cmd.ld_piv = 1'b1;
				if (sts.rd_zero) begin
					cmd.out_en    = 1'b1;
					cmd.out_abort = 1'b1;
					cmd.out_code  = ST_ZERO_PIVOT;
					cmd.out_last  = 1'b1;
				end
			end
			S_RW_RD: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(k_q, c_q, s_q);
			end
			S_RW_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_F;
			end
			S_RW_WAIT: cmd.ld_f = sts.div_done;
			S_EL_A: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(c_q, l_q, s_q);
			end
			S_EL_B: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_F;
				cmd.ram_re    = 1'b1;
				raddr         = rc(k_q, l_q, s_q);
			end
			S_EL_C: begin
				cmd.ram_we = 1'b1;
				cmd.wsel   = WR_DIFF;
				waddr      = rc(k_q, l_q, s_q);
			end
			S_FIN_RD: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(n_m1, n_m1, s_q);
			end
			S_FIN_CK: begin
				if (sts.rd_zero) begin
					cmd.out_en    = 1'b1;
					cmd.out_abort = 1'b1;
					cmd.out_code  = ST_ZERO_PIVOT;
					cmd.out_last  = 1'b1;
				end
			end
			S_BS_TOP: cmd.acc_clr = 1'b1;
			S_BS_RD: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(k_q, l_q, s_q);
			end
			S_BS_MUL: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MUL_S;
			end
			S_BS_ADD: cmd.acc_add = 1'b1;
			S_BS_NRD: begin
				cmd.ram_re = 1'b1;
				raddr      = rc(k_q, n_q, s_q);
			end
			S_BS_NUM: begin
				cmd.ld_num = 1'b1;
				cmd.ram_re = 1'b1;
				raddr      = rc(k_q, k_q, s_q);
			end
			S_BS_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_X;
			end
			S_BS_WAIT: begin
				if (sts.div_done) begin
					cmd.sol_we   = 1'b1;
					cmd.out_en   = 1'b1;
					cmd.out_last = (k_q == '0);
				end
			end
			default: ;
		endcase
	end

	// Sequencer and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lp_q    <= '0;
			n_q     <= '0;
			s_q     <= '0;
			cells_q <= '0;
			i_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			l_q     <= '0;
			r_q     <= '0;
			p_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (lp_q < cells_live) begin
							lp_q <= lp_q + 1'b1;
						end
						if (last_element) begin
							lp_q    <= '0;
							n_q     <= n_live;
							s_q     <= SZW'(n_live) + SZW'(1);
							cells_q <= cells_live;
							i_q     <= '0;
							state_q <= S_CL_RD;
						end
					end
				end
				S_CL_RD: state_q <= S_CL_WR;
				S_CL_WR: begin
					c_q <= '0;
					k_q <= '0;
					if (i_q == cells_q - 1'b1) begin
						state_q <= pivot_q ? S_EL_TOP : S_ZD_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_CL_RD;
					end
				end
				S_ZD_RD: state_q <= S_ZD_CK;
				S_ZD_CK: begin
					if (sts.rd_zero) begin
						state_q <= S_IDLE;
					end else if (k_q == n_m1) begin
						state_q <= S_EL_TOP;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_ZD_RD;
					end
				end
				S_EL_TOP: begin
					if (c_q == n_m1) begin
						state_q <= S_FIN_RD;
					end else begin
						state_q <= pivot_q ? S_PV_RD0 : S_PP_RD;
					end
				end
				S_PV_RD0: begin
					r_q     <= c_q + 1'b1;
					p_q     <= c_q;
					state_q <= S_PV_BEST;
				end
				S_PV_BEST: state_q <= S_PV_RD;
				S_PV_RD:   state_q <= S_PV_CMP;
				S_PV_CMP: begin
					p_q <= p_nx;
					if (r_q == n_m1) begin
						l_q     <= '0;
						state_q <= (p_nx != c_q) ? S_SW_A : S_PP_RD;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_PV_RD;
					end
				end
				S_SW_A: state_q <= S_SW_B;
				S_SW_B: state_q <= S_SW_C;
				S_SW_C: state_q <= S_SW_D;
				S_SW_D: begin
					if (l_q == n_q) begin
						state_q <= S_PP_RD;
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= S_SW_A;
					end
				end
				S_PP_RD: state_q <= S_PP_CK;
				S_PP_CK: begin
					k_q     <= c_q + 1'b1;
					state_q <= sts.rd_zero ? S_IDLE : S_RW_RD;
				end
				S_RW_RD:  state_q <= S_RW_DIV;
				S_RW_DIV: state_q <= S_RW_WAIT;
				S_RW_WAIT: begin
					if (sts.div_done) begin
						l_q     <= c_q;
						state_q <= S_EL_A;
					end
				end
				S_EL_A: state_q <= S_EL_B;
				S_EL_B: state_q <= S_EL_C;
				S_EL_C: begin
					if (l_q == n_q) begin
						if (k_q == n_m1) begin
							c_q     <= c_q + 1'b1;
							state_q <= S_EL_TOP;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_RW_RD;
						end
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= S_EL_A;
					end
				end
				S_FIN_RD: state_q <= S_FIN_CK;
				S_FIN_CK: begin
					k_q     <= n_m1;
					state_q <= sts.rd_zero ? S_IDLE : S_BS_TOP;
				end
				S_BS_TOP: begin
					l_q     <= n_m1;
					state_q <= (k_q != n_m1) ? S_BS_RD : S_BS_NRD;
				end
				S_BS_RD:  state_q <= S_BS_MUL;
				S_BS_MUL: state_q <= S_BS_ADD;
				S_BS_ADD: begin
					if (l_q == k_q + 1'b1) begin
						state_q <= S_BS_NRD;
					end else begin
						l_q     <= l_q - 1'b1;
						state_q <= S_BS_RD;
					end
				end
				S_BS_NRD: state_q <= S_BS_NUM;
				S_BS_NUM: state_q <= S_BS_DIV;
				S_BS_DIV: state_q <= S_BS_WAIT;
				S_BS_WAIT: begin
					if (sts.div_done) begin
						if (k_q == '0) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q - 1'b1;
							state_q <= S_BS_TOP;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ tb/tb_linear_system_gauss_solver.sv @@
// Self-checking testbench for the fixed-point Gaussian elimination solver.
`timescale 1ns / 100ps
module tb_linear_system_gauss_solver;
	import lgs_pkg::*;

	localparam int CELLS_MAX = 72;
	localparam longint VMAX = 64'sd2147483647;
	localparam int IDLE_LIMIT = 20000;
	localparam int ITEM_TARGET = 450;

	typedef struct {
		logic [31:0] sol;
		logic [2:0]  idx;
		logic [1:0]  st;
		logic        lst;
	} unknown_t;

	typedef struct {
		logic [3:0]  size;
		logic        piv;
		logic [31:0] coef;
		logic        last;
		logic        typed;
		logic [31:0] xsol;
		logic [1:0]  xst;
	} drow_t;

	logic        clk, arst_n, start, busy, last_element;
	logic        cfg_valid, cfg_ready, result_valid, last_result;
	logic signed [31:0] coefficient, solution;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic [2:0]  unknown_index;
	logic [1:0]  status;

	linear_system_gauss_solver dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coefficient(coefficient), .last_element(last_element),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid), .solution(solution),
		.unknown_index(unknown_index), .status(status), .last_result(last_result)
	);

	// Model state of the solver
	logic [3:0] cur_size;
	logic       cur_pivot;
	longint     mat[CELLS_MAX];
	longint     xval[8];
	bit         written[CELLS_MAX];
	int         load_pos;
	bit         sat_seen;
	unknown_t   solutions_due[$];

	int items_sent, systems_sent, results_checked, errors, mismatches;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Saturate a sign and magnitude to 32-bit Q16.16
	function automatic longint saturate(bit neg, longint unsigned m);
		if (!neg && m > VMAX) begin
			sat_seen = 1;
			return VMAX;
		end
		if (neg && m > VMAX + 1) begin
			sat_seen = 1;
			return -VMAX - 1;
		end
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint q_mul(longint a, longint b);
		longint unsigned m;
		m = (magn(a) * magn(b) + 64'd32768) >> 16;
		return saturate((a < 0) != (b < 0), m);
	endfunction

	// Rounded quotient, half away from zero
	function automatic longint q_div(longint a, longint b);
		longint unsigned num, den, q, r;
		if (b == 0)
			return 0;
		num = magn(a) << 16;
		den = magn(b);
		q = num / den;
		r = num % den;
		if (r >= den - r)
			q++;
		return saturate((a < 0) != (b < 0), q);
	endfunction

	function automatic longint q_clamp(longint v);
		return saturate(v < 0, magn(v));
	endfunction

	function automatic void push_abort(logic [1:0] code);
		unknown_t u;
		u.sol = 0; u.idx = 0; u.st = code; u.lst = 1;
		solutions_due.push_back(u);
	endfunction

	// Forward elimination and back substitution on the stored matrix
	function automatic void eliminate_and_solve(int n);
		int s, p;
		longint t, f, acc, x;
		longint unsigned best;
		unknown_t u;
		s = n + 1;
		sat_seen = 0;
		for (int i = 0; i < n * s; i++)
			mat[i] = q_clamp(mat[i]);
		if (!cur_pivot) begin
			for (int k = 0; k < n; k++)
				if (mat[k * s + k] == 0) begin
					push_abort(ST_ZERO_DIAG);
					return;
				end
		end
		for (int c = 0; c + 1 < n; c++) begin
			if (cur_pivot) begin
				p = c;
				best = magn(mat[c * s + c]);
				for (int r = c + 1; r < n; r++)
					if (magn(mat[r * s + c]) > best) begin
						best = magn(mat[r * s + c]);
						p = r;
					end
				for (int l = 0; l < s && p != c; l++) begin
					t = mat[c * s + l];
					mat[c * s + l] = mat[p * s + l];
					mat[p * s + l] = t;
				end
			end
			if (mat[c * s + c] == 0) begin
				push_abort(ST_ZERO_PIVOT);
				return;
			end
			for (int k = c + 1; k < n; k++) begin
				f = q_div(mat[k * s + c], mat[c * s + c]);
				for (int l = c; l < s; l++)
					mat[k * s + l] = q_clamp(mat[k * s + l] - q_mul(mat[c * s + l], f));
			end
		end
		if (mat[(n - 1) * s + n - 1] == 0) begin
			push_abort(ST_ZERO_PIVOT);
			return;
		end
		for (int k = n - 1; k >= 0; k--) begin
			acc = 0;
			for (int j = n - 1; j > k; j--)
				acc = q_clamp(acc + q_mul(mat[k * s + j], xval[j]));
			x = q_div(q_clamp(mat[k * s + n] - acc), mat[k * s + k]);
			xval[k] = x;
			u.sol = x[31:0];
			u.idx = k[2:0];
			u.st = sat_seen ? ST_SAT : ST_OK;
			u.lst = (k == 0);
			solutions_due.push_back(u);
		end
	endfunction

	function automatic int eff_size();
		return cur_size == 0 ? 1 : (cur_size > 8 ? 8 : cur_size);
	endfunction

	// Load one accepted coefficient; solve on the final element
	function automatic void load_coefficient(logic [31:0] coef, logic last);
		int n;
		n = eff_size();
		if (load_pos < n * (n + 1)) begin
			mat[load_pos] = longint'($signed(coef));
			written[load_pos] = 1;
			load_pos++;
		end
		if (last) begin
			load_pos = 0;
			eliminate_and_solve(n);
		end
	endfunction

	// Send one coefficient and wait for the transaction
	task automatic send_coef(logic [31:0] coef, logic last);
		start <= 1'b1;
		coefficient <= coef;
		last_element <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
		if (last)
			systems_sent++;
		load_coefficient(coef, last);
	endtask

	// Wait until every expected unknown is out and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (solutions_due.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the caller drops cfg_valid after the last one
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_SIZE)
			cur_size = val;
		else
			cur_pivot = val[0];
	endtask

	task automatic configure(logic [3:0] size, logic piv);
		settle();
		write_reg(CFG_SIZE, size);
		write_reg(CFG_PIVOT, {3'b0, piv});
		cfg_valid <= 1'b0;
	endtask

	// Mostly diagonally dominant content, with extremes, zeros and noise
	function automatic logic [31:0] pick_coef(int r, int c, int n);
		int sel;
		logic [31:0] m;
		sel = $urandom_range(0, 99);
		if (sel < 8)
			return $urandom;
		if (sel < 12)
			return 32'h0;
		if (sel < 13)
			return 32'h7fff_ffff;
		if (sel < 14)
			return 32'h8000_0000;
		if (c == r)
			m = $urandom_range(2 << 16, 40 << 16);
		else if (c == n)
			m = $urandom_range(0, 64 << 16);
		else
			m = $urandom_range(0, 3 << 16);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	// Burst and gap pattern of the sender
	int burst_left;
	task automatic sender_idle();
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
	endtask

	task automatic random_system();
		int n, cells, kind, len;
		bit ok;
		n = eff_size();
		cells = n * (n + 1);
		kind = $urandom_range(0, 9);
		len = cells;
		if (kind == 0 && cells > 1) begin
			len = $urandom_range(1, cells - 1);
			ok = 1;
			for (int i = len; i < cells; i++)
				ok &= written[i];
			if (!ok)
				len = cells;
		end else if (kind == 1)
			len = cells + $urandom_range(1, 3);
		for (int i = 0; i < len; i++) begin
			sender_idle();
			send_coef(kind == 2 ? $urandom : pick_coef((i % cells) / (n + 1),
				(i % cells) % (n + 1), n), i == len - 1);
		end
	endtask

	drow_t dirs[25] = '{
		'{4'd1, 1'b0, 32'h0002_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd1, 1'b0, 32'h0004_0000, 1'b1, 1'b1, 32'h0002_0000, ST_OK},
		'{4'd1, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd1, 1'b0, 32'h0005_0000, 1'b1, 1'b1, 32'h0, ST_ZERO_DIAG},
		'{4'd1, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd1, 1'b1, 32'h0005_0000, 1'b1, 1'b1, 32'h0, ST_ZERO_PIVOT},
		'{4'd1, 1'b0, 32'h0000_0001, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd1, 1'b0, 32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, ST_SAT},
		'{4'd1, 1'b0, 32'h0000_0001, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd1, 1'b0, 32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, ST_SAT},
		// extra element past the matrix is dropped
		'{4'd1, 1'b0, 32'h0002_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd1, 1'b0, 32'h0004_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd1, 1'b0, 32'h0009_0000, 1'b1, 1'b1, 32'h0002_0000, ST_OK},
		// row swap needed in pivot mode
		'{4'd2, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0001_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0002_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0003_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0004_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0005_0000, 1'b1, 1'b0, 32'h0, ST_OK},
		// all-zero pivot column
		'{4'd2, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0001_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0001_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0000_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0002_0000, 1'b0, 1'b0, 32'h0, ST_OK},
		'{4'd2, 1'b1, 32'h0003_0000, 1'b1, 1'b1, 32'h0, ST_ZERO_PIVOT}
	};

	// Compare each result transaction with the oldest expected unknown
	always @(posedge clk) begin
		unknown_t e;
		if (arst_n && result_valid) begin
			results_checked++;
			if (solutions_due.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: x%0d=%h status %0d", unknown_index,
						solution, status);
			end else begin
				e = solutions_due.pop_front();
				if (e.sol !== solution || e.idx !== unknown_index || e.st !== status
					|| e.lst !== last_result) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp x%0d=%h st %0d last %0d, got x%0d=%h st %0d last %0d",
							e.idx, e.sol, e.st, e.lst, unknown_index, solution, status,
							last_result);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	int idle_cycles;
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [3:0] sz;
		int ph;
		arst_n = 1'b0;
		start = 1'b0;
		coefficient = '0;
		last_element = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SIZE;
		cfg_data = '0;
		cur_size = SIZE_RESET;
		cur_pivot = 1'b0;
		load_pos = 0;
		sat_seen = 0;
		burst_left = 0;
		idle_cycles = 0;
		items_sent = 0; systems_sent = 0; results_checked = 0;
		errors = 0; mismatches = 0;
		foreach (written[i]) written[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dirs[i]) begin
			if (load_pos == 0 && (dirs[i].size != cur_size || dirs[i].piv != cur_pivot))
				configure(dirs[i].size, dirs[i].piv);
			send_coef(dirs[i].coef, dirs[i].last);
			if (dirs[i].typed) begin
				unknown_t u;
				void'(solutions_due.pop_back());
				u.sol = dirs[i].xsol; u.idx = 0; u.st = dirs[i].xst; u.lst = 1;
				solutions_due.push_back(u);
			end
		end

		// Random phases; first ones pin the size extremes and both modes
		ph = 0;
		while (items_sent < ITEM_TARGET) begin
			case (ph)
				0: sz = 4'd8;
				1: sz = 4'd1;
				2: sz = 4'd0;
				3: sz = 4'd15;
				default: sz = ($urandom_range(0, 7) == 0) ? 4'd8 : $urandom_range(1, 5);
			endcase
			configure(sz, ph < 2 ? ph[0] : $urandom_range(0, 1));
			repeat ($urandom_range(2, 4))
				if (items_sent < ITEM_TARGET)
					random_system();
			ph++;
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Ran %0d coefficients in %0d systems over %0d settings,", items_sent,
			systems_sent, ph + 1);
		$display("checked %0d solver results with %0d errors.", results_checked, errors);
		if (errors == 0 && solutions_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
